>>> src/sls_pkg.sv
// Shared types and constants for the slew-limited motor and servo drive.
`timescale 1ns / 1ps

package sls_pkg;

   // Fixed-point limits: duty 16384 = full, steering in 1/256 degree
   localparam logic signed [15:0] DUTY_FULL   = 16'sd16384;
   localparam logic signed [15:0] STEER_LIMIT = 16'sd23040;

   // Register reset values
   localparam logic [15:0] DUTY_RATE_RESET  = 16'd8192;
   localparam logic [15:0] STEER_RATE_RESET = 16'd7680;
   localparam logic [19:0] MAX_STEP_RESET   = 20'd50000;

   // Register map (word index = paddr[3:2])
   localparam int          CSR_ADDR_W     = 4;
   localparam logic [1:0]  REG_DUTY_RATE  = 2'd0;
   localparam logic [1:0]  REG_STEER_RATE = 2'd1;
   localparam logic [1:0]  REG_MAX_STEP   = 2'd2;

   // Servo pulse center: (600 + 900) us in 1/256 us
   localparam logic [21:0] SERVO_CENTER_Q8 = 22'd384000;

   // Exact reciprocals: x / 15625 for x < 2^29, and x / 625 for x < 2^21
   localparam logic [31:0] US_RECIP    = 32'd562949954;  // ceil(2^43 / 15625)
   localparam logic [31:0] SERVO_RECIP = 32'd3435974;    // ceil(2^31 / 625)

   // Operand selection for the shared multiplier
   typedef enum logic [2:0] {
      MUL_DUTY_RATE,
      MUL_DUTY_RECIP,
      MUL_STEER_RATE,
      MUL_STEER_RECIP,
      MUL_SERVO_RECIP
   } mul_sel_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic        load_item;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        duty_upd;
      logic        steer_upd;
      logic        servo_prep;
      logic        out_load;
   } sls_cmd_type;

endpackage

>>> src/sls_req_if.sv
// Input channel: drive update or stop command.
`timescale 1ns / 1ps

interface sls_req_if;
   logic               valid;
   logic               ready;
   logic               action;
   logic signed [15:0] target_duty;
   logic signed [15:0] target_angle;
   logic signed [19:0] step_time;

   modport source (output valid, action, target_duty, target_angle, step_time,
                   input ready);
   modport sink   (input valid, action, target_duty, target_angle, step_time,
                   output ready);
endinterface

>>> src/sls_rsp_if.sv
// Result channel: bridge levels, servo compare and applied values.
`timescale 1ns / 1ps

interface sls_rsp_if;
   logic               valid;
   logic               ready;
   logic [7:0]         forward_level;
   logic [7:0]         reverse_level;
   logic [13:0]        servo_level;
   logic signed [15:0] applied_duty;
   logic signed [15:0] applied_steering;

   modport source (output valid, forward_level, reverse_level, servo_level,
                   applied_duty, applied_steering,
                   input ready);
   modport sink   (input valid, forward_level, reverse_level, servo_level,
                   applied_duty, applied_steering,
                   output ready);
endinterface

>>> src/sls_csr.sv
// APB-style configuration registers for rates and the step clamp.
`timescale 1ns / 1ps

module sls_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [sls_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready,
   output logic [15:0]                   duty_rate,
   output logic [15:0]                   steer_rate,
   output logic [19:0]                   max_step_us
);

   logic [15:0] duty_rate_ff,  duty_rate_in;
   logic [15:0] steer_rate_ff, steer_rate_in;
   logic [19:0] max_step_ff,   max_step_in;
   logic [1:0]  reg_idx;
   logic        wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite;

   // Write decode
   always_comb begin
      duty_rate_in  = duty_rate_ff;
      steer_rate_in = steer_rate_ff;
      max_step_in   = max_step_ff;
      if (wr_en) begin
         case (reg_idx)
            sls_pkg::REG_DUTY_RATE:  duty_rate_in  = pwdata[15:0];
            sls_pkg::REG_STEER_RATE: steer_rate_in = pwdata[15:0];
            sls_pkg::REG_MAX_STEP:   max_step_in   = pwdata[19:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_rate_ff  <= sls_pkg::DUTY_RATE_RESET;
         steer_rate_ff <= sls_pkg::STEER_RATE_RESET;
         max_step_ff   <= sls_pkg::MAX_STEP_RESET;
      end else begin
         duty_rate_ff  <= duty_rate_in;
         steer_rate_ff <= steer_rate_in;
         max_step_ff   <= max_step_in;
      end
   end

   // Read mux
   always_comb begin
      case (reg_idx)
         sls_pkg::REG_DUTY_RATE:  prdata = {16'b0, duty_rate_ff};
         sls_pkg::REG_STEER_RATE: prdata = {16'b0, steer_rate_ff};
         sls_pkg::REG_MAX_STEP:   prdata = {12'b0, max_step_ff};
         default:                 prdata = '0;
      endcase
   end

   assign duty_rate   = duty_rate_ff;
   assign steer_rate  = steer_rate_ff;
   assign max_step_us = max_step_ff;

endmodule

>>> src/sls_ctrl.sv
// Sequencer that walks one update through the shared multiplier.
`timescale 1ns / 1ps

module sls_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_action,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output sls_pkg::sls_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DUTY_MUL,
      ST_DUTY_DIV,
      ST_STEER_MUL,
      ST_STEER_DIV,
      ST_STEER_UPD,
      ST_SERVO_PREP,
      ST_SERVO_DIV,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Commands and next state
   always_comb begin
      cmd           = '0;
      cmd.mul_sel   = sls_pkg::MUL_DUTY_RATE;
      state_in      = state_ff;
      cmd.load_item = req_valid && req_ready;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load_item) begin
               state_in = req_action ? ST_SERVO_PREP : ST_DUTY_MUL;
            end
         end
         ST_DUTY_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = sls_pkg::MUL_DUTY_RATE;
            state_in    = ST_DUTY_DIV;
         end
         ST_DUTY_DIV: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = sls_pkg::MUL_DUTY_RECIP;
            state_in    = ST_STEER_MUL;
         end
         ST_STEER_MUL: begin
            // duty limit is in the product register now
            cmd.duty_upd = 1'b1;
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = sls_pkg::MUL_STEER_RATE;
            state_in     = ST_STEER_DIV;
         end
         ST_STEER_DIV: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = sls_pkg::MUL_STEER_RECIP;
            state_in    = ST_STEER_UPD;
         end
         ST_STEER_UPD: begin
            cmd.steer_upd = 1'b1;
            state_in      = ST_SERVO_PREP;
         end
         ST_SERVO_PREP: begin
            cmd.servo_prep = 1'b1;
            state_in       = ST_SERVO_DIV;
         end
         ST_SERVO_DIV: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = sls_pkg::MUL_SERVO_RECIP;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            // wait for the output register to free up
            cmd.out_load = out_free;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> src/sls_datapath.sv
// Datapath: kept duty and steering, shared multiplier, output register.
`timescale 1ns / 1ps

module sls_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  sls_pkg::sls_cmd_type cmd,
   input  logic                 req_action,
   input  logic signed [15:0]   req_target_duty,
   input  logic signed [15:0]   req_target_angle,
   input  logic signed [19:0]   req_step_time,
   input  logic [15:0]          duty_rate,
   input  logic [15:0]          steer_rate,
   input  logic [19:0]          max_step_us,
   output logic [7:0]           forward_level,
   output logic [7:0]           reverse_level,
   output logic [13:0]          servo_level,
   output logic signed [15:0]   applied_duty,
   output logic signed [15:0]   applied_steering
);

   // Move cur toward tgt by at most lim
   function automatic logic signed [15:0] slew(input logic signed [15:0] cur,
                                              input logic signed [15:0] tgt,
                                              input logic [15:0]        lim);
      logic signed [17:0] diff;
      logic signed [17:0] lim_s;
      logic signed [17:0] delta;
      diff  = 18'(tgt) - 18'(cur);
      lim_s = signed'({2'b00, lim});
      if (diff > lim_s) begin
         delta = lim_s;
      end else if (diff < -lim_s) begin
         delta = -lim_s;
      end else begin
         delta = diff;
      end
      return 16'(18'(cur) + delta);
   endfunction

   logic signed [15:0] duty_ff, steer_ff;
   logic signed [15:0] tgt_duty_ff, tgt_angle_ff;
   logic signed [15:0] tgt_duty_in, tgt_angle_in;
   logic [18:0]        step_ff, step_in;
   logic [63:0]        prod_ff, prod_in;
   logic [31:0]        mul_a, mul_b;
   logic [20:0]        servo_x_ff, servo_x_in;
   logic [7:0]         fwd_ff, rev_ff;
   logic [13:0]        servo_ff;
   logic signed [15:0] out_duty_ff, out_steer_ff;

   // Input conditioning: saturate targets, clamp elapsed time
   always_comb begin
      if (req_target_duty > sls_pkg::DUTY_FULL) begin
         tgt_duty_in = sls_pkg::DUTY_FULL;
      end else if (req_target_duty < -sls_pkg::DUTY_FULL) begin
         tgt_duty_in = -sls_pkg::DUTY_FULL;
      end else begin
         tgt_duty_in = req_target_duty;
      end
      if (req_target_angle > sls_pkg::STEER_LIMIT) begin
         tgt_angle_in = sls_pkg::STEER_LIMIT;
      end else if (req_target_angle < -sls_pkg::STEER_LIMIT) begin
         tgt_angle_in = -sls_pkg::STEER_LIMIT;
      end else begin
         tgt_angle_in = req_target_angle;
      end
      if (req_step_time[19]) begin
         step_in = '0;
      end else if ({1'b0, req_step_time[18:0]} > max_step_us) begin
         step_in = max_step_us[18:0];
      end else begin
         step_in = req_step_time[18:0];
      end
   end

   // Shared multiplier operand select
   always_comb begin
      case (cmd.mul_sel)
         sls_pkg::MUL_DUTY_RATE: begin
            mul_a = {16'b0, duty_rate};
            mul_b = {13'b0, step_ff};
         end
         sls_pkg::MUL_STEER_RATE: begin
            mul_a = {16'b0, steer_rate};
            mul_b = {13'b0, step_ff};
         end
         sls_pkg::MUL_DUTY_RECIP, sls_pkg::MUL_STEER_RECIP: begin
            // (rate*step >> 6) / 15625 == rate*step / 1000000
            mul_a = {3'b0, prod_ff[34:6]};
            mul_b = sls_pkg::US_RECIP;
         end
         sls_pkg::MUL_SERVO_RECIP: begin
            mul_a = {11'b0, servo_x_ff};
            mul_b = sls_pkg::SERVO_RECIP;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = {32'b0, mul_a} * {32'b0, mul_b};

   // Servo numerator: pulse*16383 >> 13, divided by 625 afterwards
   always_comb begin
      logic signed [21:0] ten_steer;
      logic [19:0]        pulse;
      logic [33:0]        scaled;
      ten_steer  = (22'(steer_ff) <<< 3) + (22'(steer_ff) <<< 1);
      pulse      = 20'(sls_pkg::SERVO_CENTER_Q8 - ten_steer);
      scaled     = ({14'b0, pulse} << 14) - {14'b0, pulse};
      servo_x_in = scaled[33:13];
   end

   // Kept state
   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff  <= '0;
         steer_ff <= '0;
      end else begin
         if (cmd.load_item && req_action) begin
            duty_ff <= '0;
         end else if (cmd.duty_upd) begin
            duty_ff <= slew(duty_ff, tgt_duty_ff, prod_ff[58:43]);
         end
         if (cmd.steer_upd) begin
            steer_ff <= slew(steer_ff, tgt_angle_ff, prod_ff[58:43]);
         end
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         tgt_duty_ff  <= tgt_duty_in;
         tgt_angle_ff <= tgt_angle_in;
         step_ff      <= step_in;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.servo_prep) begin
         servo_x_ff <= servo_x_in;
      end
   end

   // Output register: bridge level is |duty|*255 >> 14
   always_ff @(posedge clock) begin
      logic [14:0] mag;
      logic [22:0] mag255;
      if (cmd.out_load) begin
         mag    = duty_ff[15] ? 15'(-duty_ff) : duty_ff[14:0];
         mag255 = {mag, 8'b0} - {8'b0, mag};
         fwd_ff       <= duty_ff[15] ? 8'd0 : mag255[21:14];
         rev_ff       <= duty_ff[15] ? mag255[21:14] : 8'd0;
         servo_ff     <= prod_ff[44:31];
         out_duty_ff  <= duty_ff;
         out_steer_ff <= steer_ff;
      end
   end

   assign forward_level    = fwd_ff;
   assign reverse_level    = rev_ff;
   assign servo_level      = servo_ff;
   assign applied_duty     = out_duty_ff;
   assign applied_steering = out_steer_ff;

endmodule

>>> src/slew_limited_motor_servo_drive_top.sv
// Top level of the slew-limited motor and servo drive.
`timescale 1ns / 1ps

// Each accepted request either applies a duty and steering target over an
// elapsed time (clamped to 0..max_step_us) or stops the drive. Duty and
// steering move toward their saturated targets by at most rate*step/1e6 and
// the result carries the H-bridge levels, a 14-bit servo compare for a 20 ms
// frame and the applied values. One 32x32 multiplier is shared by the rate
// products, the divide-by-10^6 reciprocals and the servo scaling, so a new
// request is taken only after the previous one has been stepped through
// them and its result loaded; a stop skips the rate steps. The result
// sits in an output register; a new request is taken while it waits, but
// its own result is held back until the previous one has been taken.
// Registers are at byte addresses 0 (duty_rate), 4 (steer_rate) and
// 8 (max_step_us); pready is always high.

module slew_limited_motor_servo_drive_top (
   input  logic                          clock,
   input  logic                          reset,
   sls_req_if.sink                       req_chan,
   sls_rsp_if.source                     rsp_chan,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [sls_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   sls_pkg::sls_cmd_type cmd;
   logic [15:0]          duty_rate;
   logic [15:0]          steer_rate;
   logic [19:0]          max_step_us;

   sls_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (csr_psel),
      .penable     (csr_penable),
      .pwrite      (csr_pwrite),
      .paddr       (csr_paddr),
      .pwdata      (csr_pwdata),
      .prdata      (csr_prdata),
      .pready      (csr_pready),
      .duty_rate   (duty_rate),
      .steer_rate  (steer_rate),
      .max_step_us (max_step_us)
   );

   sls_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .req_ready  (req_chan.ready),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .cmd        (cmd)
   );

   sls_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_action       (req_chan.action),
      .req_target_duty  (req_chan.target_duty),
      .req_target_angle (req_chan.target_angle),
      .req_step_time    (req_chan.step_time),
      .duty_rate        (duty_rate),
      .steer_rate       (steer_rate),
      .max_step_us      (max_step_us),
      .forward_level    (rsp_chan.forward_level),
      .reverse_level    (rsp_chan.reverse_level),
      .servo_level      (rsp_chan.servo_level),
      .applied_duty     (rsp_chan.applied_duty),
      .applied_steering (rsp_chan.applied_steering)
   );

   // Output register is never overwritten while a result is pending
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("result register loaded over a pending result");

   // State-changing commands never overlap
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_item, cmd.duty_upd, cmd.steer_upd, cmd.servo_prep,
                cmd.out_load}))
      else $error("overlapping datapath commands");

   // A result only appears after the sequencer loaded it
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(cmd.out_load))
      else $error("result valid without an output load");

   // After a request transfer the block is busy in the following cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request taken while the previous one is in progress");

endmodule
